FILE: design/lfps_pkg.sv
// Shared types, constants and lookup functions for the line-follow PWM steering core.
package lfps_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_PWM_PERIOD = 2'd0;
  localparam logic [1:0] REG_BASE_SPEED = 2'd1;

  // Register reset values.
  localparam logic [15:0] PWM_PERIOD_RESET = 16'd533;
  localparam logic [6:0]  BASE_SPEED_RESET = 7'd50;

  // Speed magnitude limits and lamp count that forces a stop.
  localparam logic [6:0] SPEED_MIN  = 7'd5;
  localparam logic [6:0] SPEED_MAX  = 7'd100;
  localparam logic [3:0] STOP_ZEROS = 4'd5;

  // Compare is floor(period * (OFFSET_BASE + t) / 250). The product is halved
  // and then divided by DIV_LO through a reciprocal multiply and one fixup.
  localparam logic [7:0]  OFFSET_BASE = 8'd150;
  localparam logic [6:0]  DIV_LO      = 7'd125;
  localparam logic [17:0] RECIP       = 18'd134217;   // floor(2^24 / 125)
  localparam int          RECIP_SHIFT = 24;

  // Per-wheel command leaving the steering stage.
  typedef struct packed {
    logic [6:0] mag;   // clamped magnitude, 5..100
    logic       pos;   // speed above zero
    logic       neg;   // speed below zero
  } wheel_cmd_t;

  // Load enables for the stages inside the wheel compare pipeline.
  typedef struct packed {
    logic ld2;
    logic ld3;
    logic ld4;
  } stage_en_t;

  // Left wheel offset for the lowest lamp that is off.
  function automatic logic signed [8:0] left_offset(input logic [2:0] idx);
    logic signed [8:0] o;
    begin
      case (idx)
        3'd0: o = 9'sd60;
        3'd1: o = 9'sd40;
        3'd2: o = 9'sd30;
        3'd3: o = 9'sd0;
        3'd4: o = -9'sd30;
        3'd5: o = -9'sd70;
        default: o = -9'sd120;
      endcase
      return o;
    end
  endfunction

  // Right wheel offset for the lowest lamp that is off.
  function automatic logic signed [8:0] right_offset(input logic [2:0] idx);
    logic signed [8:0] o;
    begin
      case (idx)
        3'd0: o = -9'sd120;
        3'd1: o = -9'sd70;
        3'd2: o = -9'sd30;
        3'd3: o = 9'sd0;
        3'd4: o = 9'sd30;
        3'd5: o = 9'sd40;
        default: o = 9'sd60;
      endcase
      return o;
    end
  endfunction

endpackage

FILE: design/lfps_if.sv
// Valid/ready channel interfaces for sensor samples and PWM drive words.

interface lfps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sensor_bits;

  modport source (output valid, output sensor_bits, input ready);
  modport sink (input valid, input sensor_bits, output ready);
endinterface

interface lfps_out_if;
  logic        valid;
  logic        ready;
  logic        stop_now;
  logic [15:0] left_forward_compare;
  logic [15:0] left_reverse_compare;
  logic        left_forward_invert;
  logic        left_reverse_invert;
  logic [15:0] right_forward_compare;
  logic [15:0] right_reverse_compare;
  logic        right_forward_invert;
  logic        right_reverse_invert;

  modport source (
    output valid, output stop_now,
    output left_forward_compare, output left_reverse_compare,
    output left_forward_invert, output left_reverse_invert,
    output right_forward_compare, output right_reverse_compare,
    output right_forward_invert, output right_reverse_invert,
    input ready
  );
  modport sink (
    input valid, input stop_now,
    input left_forward_compare, input left_reverse_compare,
    input left_forward_invert, input left_reverse_invert,
    input right_forward_compare, input right_reverse_compare,
    input right_forward_invert, input right_reverse_invert,
    output ready
  );
endinterface

FILE: design/lfps_steer.sv
// First stage: lamp decode, stop detect and signed wheel speed per side.
module lfps_steer (
  input  logic                clk,
  input  logic                ld,
  input  logic [7:0]          sensor_bits,
  input  logic [6:0]          base_speed,
  output logic                stop,
  output lfps_pkg::wheel_cmd_t left_cmd,
  output lfps_pkg::wheel_cmd_t right_cmd
);

  logic [3:0]           zeros;
  logic [2:0]           lowest;
  logic                 any_off;
  logic                 stop_c;
  logic signed [8:0]    left_speed;
  logic signed [8:0]    right_speed;
  lfps_pkg::wheel_cmd_t left_c;
  lfps_pkg::wheel_cmd_t right_c;

  // Turn a signed speed into a clamped magnitude and a direction.
  function automatic lfps_pkg::wheel_cmd_t to_cmd(input logic signed [8:0] s);
    lfps_pkg::wheel_cmd_t c;
    logic [8:0]           mag;
    begin
      mag   = s[8] ? 9'(-s) : 9'(s);
      c.pos = !s[8] && (s != 9'sd0);
      c.neg = s[8];
      if (s == 9'sd0) begin
        c.mag = lfps_pkg::SPEED_MAX;
      end else if (mag > 9'(lfps_pkg::SPEED_MAX)) begin
        c.mag = lfps_pkg::SPEED_MAX;
      end else if (mag < 9'(lfps_pkg::SPEED_MIN)) begin
        c.mag = lfps_pkg::SPEED_MIN;
      end else begin
        c.mag = mag[6:0];
      end
      return c;
    end
  endfunction

  // Count dark lamps and find the lowest one.
  always_comb begin
    zeros   = 4'd0;
    lowest  = 3'd0;
    any_off = 1'b0;
    for (int i = 0; i < 8; i++) begin
      zeros = zeros + {3'd0, ~sensor_bits[i]};
    end
    for (int i = 7; i >= 0; i--) begin
      if (!sensor_bits[i]) begin
        lowest  = 3'(i);
        any_off = 1'b1;
      end
    end
  end

  // Wheel speeds: stop, straight at base speed, or base plus a steering offset.
  always_comb begin
    stop_c = (zeros >= lfps_pkg::STOP_ZEROS);
    if (stop_c) begin
      left_speed  = 9'sd0;
      right_speed = 9'sd0;
    end else if (any_off) begin
      left_speed  = $signed({2'b00, base_speed}) + lfps_pkg::left_offset(lowest);
      right_speed = $signed({2'b00, base_speed}) + lfps_pkg::right_offset(lowest);
    end else begin
      left_speed  = $signed({2'b00, base_speed});
      right_speed = $signed({2'b00, base_speed});
    end
    left_c  = to_cmd(left_speed);
    right_c = to_cmd(right_speed);
  end

  // Stage register.
  always_ff @(posedge clk) begin
    if (ld) begin
      stop      <= stop_c;
      left_cmd  <= left_c;
      right_cmd <= right_c;
    end
  end

endmodule

FILE: design/lfps_wheel.sv
// Stages two to four for one wheel: scale by period, divide by 250, map channels.
module lfps_wheel (
  input  logic                 clk,
  input  lfps_pkg::stage_en_t  en,
  input  lfps_pkg::wheel_cmd_t cmd,
  input  logic [15:0]          pwm_period,
  output logic [15:0]          forward_compare,
  output logic [15:0]          reverse_compare,
  output logic                 forward_invert,
  output logic                 reverse_invert
);

  // Stage two holds half of period * (150 + t).
  logic [22:0] half2;
  logic        pos2;
  logic        neg2;
  // Stage three holds the quotient estimate and the dividend.
  logic [22:0] half3;
  logic [16:0] est3;
  logic        pos3;
  logic        neg3;

  logic [23:0] scaled;
  logic [40:0] recip_prod;
  logic [22:0] rem;
  logic [16:0] quot;
  logic [15:0] fwd_raw;
  logic [15:0] rev_raw;

  // Period times the table step.
  assign scaled = 24'(pwm_period) * 24'(lfps_pkg::OFFSET_BASE + {1'b0, cmd.mag});

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      half2 <= scaled[23:1];
      pos2  <= cmd.pos;
      neg2  <= cmd.neg;
    end
  end

  // Reciprocal multiply; the estimate is the quotient or one below it.
  assign recip_prod = 41'(half2) * 41'(lfps_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (en.ld3) begin
      half3 <= half2;
      est3  <= recip_prod[40:lfps_pkg::RECIP_SHIFT];
      pos3  <= pos2;
      neg3  <= neg2;
    end
  end

  // Remainder check fixes the estimate, then the channels are assigned.
  always_comb begin
    rem     = half3 - 23'(est3) * 23'(lfps_pkg::DIV_LO);
    quot    = (rem >= 23'(lfps_pkg::DIV_LO)) ? est3 + 17'd1 : est3;
    fwd_raw = neg3 ? 16'd0 : quot[15:0];
    rev_raw = pos3 ? 16'd0 : quot[15:0];
  end

  // A zero compare becomes the period with the channel held idle.
  always_ff @(posedge clk) begin
    if (en.ld4) begin
      forward_invert  <= (fwd_raw == 16'd0);
      reverse_invert  <= (rev_raw == 16'd0);
      forward_compare <= (fwd_raw == 16'd0) ? pwm_period : fwd_raw;
      reverse_compare <= (rev_raw == 16'd0) ? pwm_period : rev_raw;
    end
  end

endmodule

FILE: design/line_follow_pwm_steering_core.sv
// An accepted sample's drive word shows after it passes all four register stages.
// Throughput: one sample per cycle when nothing stalls; four register stages
// (decode, period scale, reciprocal multiply, fixup and channel map) each hold
// one word, a full stage holds its word while the next one stalls, and an empty
// stage always loads.
// Reset (rst, synchronous): clears all stage valid bits and loads pwm_period 533
// and base_speed 50.
module line_follow_pwm_steering_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  lfps_in_if.sink     sample,
  lfps_out_if.source  drive
);

  logic [15:0] pwm_period;
  logic [6:0]  base_speed;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  logic stop1, stop2, stop3, stop4;

  lfps_pkg::wheel_cmd_t left_cmd;
  lfps_pkg::wheel_cmd_t right_cmd;
  lfps_pkg::stage_en_t  en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= lfps_pkg::PWM_PERIOD_RESET;
      base_speed <= lfps_pkg::BASE_SPEED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lfps_pkg::REG_PWM_PERIOD: pwm_period <= cfg_data;
        lfps_pkg::REG_BASE_SPEED: base_speed <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its word moves on.
  assign rdy4 = !v4 || drive.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign sample.ready = rdy1;

  assign en.ld2 = rdy2;
  assign en.ld3 = rdy3;
  assign en.ld4 = rdy4;

  // Valid bits travel with the words.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= sample.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  // Stop flag follows the wheel pipeline.
  always_ff @(posedge clk) begin
    if (rdy2) stop2 <= stop1;
    if (rdy3) stop3 <= stop2;
    if (rdy4) stop4 <= stop3;
  end

  lfps_steer u_steer (
    .clk         (clk),
    .ld          (rdy1),
    .sensor_bits (sample.sensor_bits),
    .base_speed  (base_speed),
    .stop        (stop1),
    .left_cmd    (left_cmd),
    .right_cmd   (right_cmd)
  );

  lfps_wheel u_left (
    .clk             (clk),
    .en              (en),
    .cmd             (left_cmd),
    .pwm_period      (pwm_period),
    .forward_compare (drive.left_forward_compare),
    .reverse_compare (drive.left_reverse_compare),
    .forward_invert  (drive.left_forward_invert),
    .reverse_invert  (drive.left_reverse_invert)
  );

  lfps_wheel u_right (
    .clk             (clk),
    .en              (en),
    .cmd             (right_cmd),
    .pwm_period      (pwm_period),
    .forward_compare (drive.right_forward_compare),
    .reverse_compare (drive.right_reverse_compare),
    .forward_invert  (drive.right_forward_invert),
    .reverse_invert  (drive.right_reverse_invert)
  );

  assign drive.valid    = v4;
  assign drive.stop_now = stop4;

  // An accepted sample always lands in the first stage.
  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> v1)
    else $error("accepted sample did not enter the first stage");

  // A stop brakes both channels of both wheels with equal compares.
  a_stop_brakes: assert property (@(posedge clk) disable iff (rst)
    drive.valid && drive.stop_now |->
      drive.left_forward_compare == drive.left_reverse_compare &&
      drive.right_forward_compare == drive.right_reverse_compare)
    else $error("stop word does not brake both wheels");

  // Either one channel idles or the wheel brakes.
  a_one_side_idle: assert property (@(posedge clk) disable iff (rst)
    drive.valid |->
      (drive.left_forward_invert || drive.left_reverse_invert ||
       drive.left_forward_compare == drive.left_reverse_compare) &&
      (drive.right_forward_invert || drive.right_reverse_invert ||
       drive.right_forward_compare == drive.right_reverse_compare))
    else $error("both channels of a wheel driven with different compares");

  // No compare exceeds the timer top.
  a_compare_in_range: assert property (@(posedge clk) disable iff (rst)
    drive.valid |->
      drive.left_forward_compare <= pwm_period &&
      drive.left_reverse_compare <= pwm_period &&
      drive.right_forward_compare <= pwm_period &&
      drive.right_reverse_compare <= pwm_period)
    else $error("compare above pwm period");

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the line-follow PWM steering core.
module tb;

  // Writes to these indexes must leave both registers untouched.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  // Steering offsets per lowest dark lamp, left and right wheel.
  localparam int LEFT_STEER[8]  = '{60, 40, 30, 0, -30, -70, -120, -120};
  localparam int RIGHT_STEER[8] = '{-120, -70, -30, 0, 30, 40, 60, 60};

  // One drive word as it leaves the block.
  typedef struct packed {
    logic        stop_now;
    logic [15:0] lf_cmp;
    logic [15:0] lr_cmp;
    logic        lf_inv;
    logic        lr_inv;
    logic [15:0] rf_cmp;
    logic [15:0] rr_cmp;
    logic        rf_inv;
    logic        rr_inv;
  } drive_word_t;

  // Predicts drive words from accepted samples and checks them in order.
  class steer_checker;
    logic [15:0] period;
    logic [6:0]  base;
    drive_word_t pending_words[$];
    int          mismatches;
    int          checked;
    int          stops;
    int          samples;

    function new();
      period = lfps_pkg::PWM_PERIOD_RESET;
      base   = lfps_pkg::BASE_SPEED_RESET;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      if (idx == lfps_pkg::REG_PWM_PERIOD) period = data;
      else if (idx == lfps_pkg::REG_BASE_SPEED) base = data[6:0];
    endfunction

    // Compare value for a clamped magnitude t in 5..100.
    function int unsigned duty_compare(int unsigned t);
      return (int'(period) * (150 + t)) / 250;
    endfunction

    // Maps a signed wheel speed onto forward and reverse channels.
    function void map_wheel(int s, output logic [15:0] fc, output logic [15:0] rc,
                            output logic fi, output logic ri);
      int unsigned mag;
      int unsigned fwd;
      int unsigned rev;
      mag = (s < 0) ? -s : s;
      if (mag > 100) mag = 100;
      if (mag < 5) mag = 5;
      if (s == 0) begin
        fwd = duty_compare(100);
        rev = fwd;
      end else if (s > 0) begin
        fwd = duty_compare(mag);
        rev = 0;
      end else begin
        fwd = 0;
        rev = duty_compare(mag);
      end
      // A zero compare parks the channel at the period with the output inverted.
      fi = (fwd == 0);
      ri = (rev == 0);
      fc = fi ? period : fwd[15:0];
      rc = ri ? period : rev[15:0];
    endfunction

    function drive_word_t predict_word(logic [7:0] bits);
      drive_word_t w;
      int dark;
      int lowest;
      int ls;
      int rs;
      dark   = 0;
      lowest = -1;
      for (int i = 0; i < 8; i++) begin
        if (!bits[i]) begin
          dark++;
          if (lowest < 0) lowest = i;
        end
      end
      if (dark >= 5) begin
        w.stop_now = 1'b1;
        ls = 0;
        rs = 0;
      end else begin
        w.stop_now = 1'b0;
        ls = base;
        rs = base;
        if (lowest >= 0) begin
          ls += LEFT_STEER[lowest];
          rs += RIGHT_STEER[lowest];
        end
      end
      map_wheel(ls, w.lf_cmp, w.lr_cmp, w.lf_inv, w.lr_inv);
      map_wheel(rs, w.rf_cmp, w.rr_cmp, w.rf_inv, w.rr_inv);
      return w;
    endfunction

    function void note_sample(logic [7:0] bits);
      samples++;
      pending_words.push_back(predict_word(bits));
    endfunction

    function string show(drive_word_t w);
      return $sformatf("stop=%0b L(f=%0d r=%0d fi=%0b ri=%0b) R(f=%0d r=%0d fi=%0b ri=%0b)",
                       w.stop_now, w.lf_cmp, w.lr_cmp, w.lf_inv, w.lr_inv,
                       w.rf_cmp, w.rr_cmp, w.rf_inv, w.rr_inv);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR: %s", msg);
    endfunction

    function void check_word(drive_word_t got);
      drive_word_t want;
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word %s", show(got)));
        return;
      end
      want = pending_words.pop_front();
      checked++;
      if (want.stop_now) stops++;
      if (got !== want)
        report($sformatf("word %0d\n  expected %s\n  actual   %s",
                         checked, show(want), show(got)));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  steer_checker sb;
  int          settings_run;

  lfps_in_if  sample_ch();
  lfps_out_if drive_ch();

  line_follow_pwm_steering_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .drive     (drive_ch)
  );

  always #2 clk = ~clk;

  // Watch both channels; a sample is noted before the word of the same edge is checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_ch.valid && sample_ch.ready) sb.note_sample(sample_ch.sensor_bits);
      if (drive_ch.valid && drive_ch.ready)
        sb.check_word('{drive_ch.stop_now,
                        drive_ch.left_forward_compare, drive_ch.left_reverse_compare,
                        drive_ch.left_forward_invert, drive_ch.left_reverse_invert,
                        drive_ch.right_forward_compare, drive_ch.right_reverse_compare,
                        drive_ch.right_forward_invert, drive_ch.right_reverse_invert});
    end
  end

  // Receiver back-pressure: modes that each last a random stretch of cycles.
  int stall_mode;
  int stall_left;
  int stall_phase;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      0: drive_ch.ready <= 1'b1;
      1: drive_ch.ready <= 1'($urandom_range(0, 1));
      2: drive_ch.ready <= (stall_phase % 4 == 0);
      default: drive_ch.ready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  // Random sample: mostly uniform, many followable patterns, a few extremes.
  function automatic logic [7:0] random_sample();
    logic [7:0] bits;
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: bits = 8'($urandom);
      5, 6, 7, 8: begin
        bits = 8'hFF;
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) bits[$urandom_range(0, 7)] = 1'b0;
      end
      default: bits = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    endcase
    return bits;
  endfunction

  // Present one word and hold it until the block takes it.
  task automatic send_sample(input logic [7:0] bits);
    sample_ch.valid       <= 1'b1;
    sample_ch.sensor_bits <= bits;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
  endtask

  // Random words in bursts with random gaps between them.
  task automatic stream_samples(input int count);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      for (int k = 0; k < burst && sent < count; k++) begin
        send_sample(random_sample());
        sent++;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        sample_ch.valid       <= 1'b0;
        sample_ch.sensor_bits <= 8'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    sample_ch.valid <= 1'b0;
  endtask

  // Wait until every predicted word has come out, then let the pipeline empty.
  task automatic drain();
    while (sb.pending_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Write both registers and both spare indexes in consecutive cycles.
  task automatic set_config(input logic [15:0] period, input logic [6:0] base);
    logic [15:0] junk;
    settings_run++;
    cfg_we    <= 1'b1;
    cfg_index <= lfps_pkg::REG_PWM_PERIOD;
    cfg_data  <= period;
    sb.write_reg(lfps_pkg::REG_PWM_PERIOD, period);
    @(posedge clk);
    cfg_index <= lfps_pkg::REG_BASE_SPEED;
    cfg_data  <= {9'd0, base};
    sb.write_reg(lfps_pkg::REG_BASE_SPEED, {9'd0, base});
    @(posedge clk);
    junk = 16'($urandom);
    cfg_index <= REG_SPARE_A;
    cfg_data  <= junk;
    sb.write_reg(REG_SPARE_A, junk);
    @(posedge clk);
    junk = 16'($urandom);
    cfg_index <= REG_SPARE_B;
    cfg_data  <= junk;
    sb.write_reg(REG_SPARE_B, junk);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Run time limit far above the slowest legal run.
  initial begin
    #1600000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [7:0] directed[$];
    sb                    = new();
    settings_run          = 1;
    stall_left            = 0;
    stall_phase           = 0;
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = lfps_pkg::REG_PWM_PERIOD;
    cfg_data              = 16'd0;
    sample_ch.valid       = 1'b0;
    sample_ch.sensor_bits = 8'd0;
    drive_ch.ready        = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed words at reset settings: straight, full stop, each single dark
    // lamp, four dark lamps (still following), five dark lamps (stop).
    directed = '{8'hFF, 8'h00, 8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF,
                 8'h7F, 8'hF0, 8'h0F, 8'hE0, 8'h07, 8'h3F, 8'hAA, 8'h55};
    foreach (directed[i]) send_sample(directed[i]);
    stream_samples(120);
    drain();

    // Extremes of both registers, a zero period, a tiny base speed, then random.
    set_config(16'hFFFF, 7'd100);
    stream_samples(130);
    drain();
    set_config(16'd1, 7'd0);
    stream_samples(130);
    drain();
    set_config(16'd0, 7'd100);
    stream_samples(130);
    drain();
    set_config(16'd533, 7'd3);
    stream_samples(130);
    drain();
    set_config(16'd2, 7'd70);
    stream_samples(130);
    drain();
    for (int p = 0; p < 3; p++) begin
      set_config(16'($urandom_range(1, 65535)), 7'($urandom_range(0, 100)));
      stream_samples(130);
      drain();
    end

    $display("Sent %0d sensor samples under %0d register settings.",
             sb.samples, settings_run);
    $display("Checked %0d drive words, %0d of them stops; %0d mismatches.",
             sb.checked, sb.stops, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_words.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
